// ----- rtl/core/srr_pkg.sv -----
package srr_pkg;

  // field widths of one transaction
  localparam int SEQ_W    = 32;
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 16;
  localparam int TAG_W    = 32;
  localparam int STATUS_W = 3;

  // most operations released by one arrival
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_RELEASED  = 3'd0,
    ST_STORED    = 3'd1,
    ST_STALE     = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_BEYOND    = 3'd4
  } status_t;

  // payload held in one slot
  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  position;
    logic [TAG_W-1:0]         value_tag;
  } slot_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_LOOK,
    S_LOAD,
    S_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    capture;
    logic    store;
    logic    release_op;
    logic    load_status;
    logic    load_rel;
    status_t status_code;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic    drop;
    status_t drop_code;
    logic    rel_ready;
    logic    out_last;
  } sts_t;

endpackage

// ----- rtl/core/srr_ctrl.sv -----
module srr_ctrl
  import srr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = sts.drop ? S_OUT : S_LOOK;
      end
      S_LOOK: begin
        state_nxt = sts.rel_ready ? S_LOAD : S_OUT;
      end
      S_LOAD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = sts.out_last ? S_IDLE : S_LOOK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs and commands
  always_comb begin
    in_stall        = 1'b1;
    out_valid       = 1'b0;
    cmd.capture     = 1'b0;
    cmd.store       = 1'b0;
    cmd.release_op  = 1'b0;
    cmd.load_status = 1'b0;
    cmd.load_rel    = 1'b0;
    cmd.status_code = ST_STORED;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_EVAL: begin
        if (sts.drop) begin
          cmd.load_status = 1'b1;
          cmd.status_code = sts.drop_code;
        end else begin
          cmd.store = 1'b1;
        end
      end
      S_LOOK: begin
        if (sts.rel_ready) begin
          cmd.release_op = 1'b1;
        end else begin
          cmd.load_status = 1'b1;
          cmd.status_code = ST_STORED;
        end
      end
      S_LOAD: begin
        cmd.load_rel = 1'b1;
      end
      S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // one transaction at a time: no second accept straight after the first
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous transaction in progress");

  // after the final result is taken the block is ready again
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && sts.out_last) |=> !in_stall)
    else $error("not ready after final result");

  // results never shown while input is being taken
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall))
    else $error("result valid while accepting input");
`endif

endmodule

// ----- rtl/core/srr_datapath.sv -----
module srr_datapath
  import srr_pkg::*;
#(
  parameter int WINDOW = 16
)(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [SEQ_W-1:0]        in_seq,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic signed [POS_W-1:0] in_position,
  input  logic [TAG_W-1:0]        in_value_tag,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  output logic [STATUS_W-1:0]     out_status,
  output logic [SEQ_W-1:0]        out_seq,
  output logic [FUNC_W-1:0]       out_func,
  output logic signed [POS_W-1:0] out_position,
  output logic [TAG_W-1:0]        out_value_tag,
  output logic                    out_last
);

  localparam int IW = $clog2(WINDOW);

  // captured transaction
  logic [SEQ_W-1:0] seq_r;
  slot_t            op_r;

  // window state
  logic [SEQ_W-1:0]  exp_r, exp_nxt;
  logic [IW-1:0]     exp_idx_r, exp_idx_nxt;
  logic [WINDOW-1:0] full_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SEQ_W-1:0]  rel_seq_r;

  // slot memory and its registered read
  slot_t mem [WINDOW];
  slot_t rd_r;

  // result register
  status_t                 out_status_r;
  logic [SEQ_W-1:0]        out_seq_r;
  slot_t                   out_op_r;
  logic                    out_last_r;

  // classification of the captured transaction
  logic [SEQ_W-1:0] diff;
  logic [IW:0]      idx_sum;
  logic [IW-1:0]    slot_idx;
  logic             stale, beyond, dup;

  assign diff    = seq_r - exp_r;
  assign idx_sum = {1'b0, exp_idx_r} + {1'b0, diff[IW-1:0]};
  assign slot_idx = (idx_sum >= (IW+1)'(WINDOW)) ? IW'(idx_sum - (IW+1)'(WINDOW))
                                                 : idx_sum[IW-1:0];
  assign stale  = seq_r < exp_r;
  assign beyond = diff >= SEQ_W'(WINDOW);
  assign dup    = full_r[slot_idx];

  always_comb begin
    sts.drop      = stale | beyond | dup;
    sts.drop_code = stale ? ST_STALE : (beyond ? ST_BEYOND : ST_DUPLICATE);
    sts.rel_ready = full_r[exp_idx_r] && (cnt_r < CNT_W'(MAX_OUT));
    sts.out_last  = out_last_r;
  end

  // expected number and its slot, wrapping to slot zero with the counter
  always_comb begin
    exp_nxt = exp_r + SEQ_W'(1);
    if (exp_r == {SEQ_W{1'b1}}) begin
      exp_idx_nxt = '0;
    end else if (exp_idx_r == IW'(WINDOW - 1)) begin
      exp_idx_nxt = '0;
    end else begin
      exp_idx_nxt = exp_idx_r + IW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r     <= SEQ_W'(1);
      exp_idx_r <= IW'(1 % WINDOW);
      full_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (cmd.capture) cnt_r <= '0;
      if (cmd.store) full_r[slot_idx] <= 1'b1;
      if (cmd.release_op) begin
        full_r[exp_idx_r] <= 1'b0;
        exp_r             <= exp_nxt;
        exp_idx_r         <= exp_idx_nxt;
        cnt_r             <= cnt_r + CNT_W'(1);
      end
    end
  end

  // capture of the arriving transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seq_r           <= in_seq;
      op_r.func       <= in_func;
      op_r.position   <= in_position;
      op_r.value_tag  <= in_value_tag;
    end
    if (cmd.release_op) rel_seq_r <= exp_r;
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (cmd.store) mem[slot_idx] <= op_r;
    if (cmd.release_op) rd_r <= mem[exp_idx_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      out_status_r <= cmd.status_code;
      out_seq_r    <= seq_r;
      out_op_r     <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_rel) begin
      out_status_r <= ST_RELEASED;
      out_seq_r    <= rel_seq_r;
      out_op_r     <= rd_r;
      out_last_r   <= !sts.rel_ready;
    end
  end

  assign out_status    = out_status_r;
  assign out_seq       = out_seq_r;
  assign out_func      = out_op_r.func;
  assign out_position  = out_op_r.position;
  assign out_value_tag = out_op_r.value_tag;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  // a stored slot is marked held
  a_store_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> full_r[$past(slot_idx)])
    else $error("stored slot not marked full");

  // a released slot is freed
  a_release_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.release_op |=> !full_r[$past(exp_idx_r)])
    else $error("released slot still marked full");

  // release count stays within the cap
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_OUT))
    else $error("release count beyond cap");
`endif

endmodule

// ----- rtl/core/sequence_reorder_release.sv -----
// Sequence reorder buffer: operations arrive tagged with sequence numbers in any
// order; stale, duplicate and out-of-window ones are answered with a single status
// result, others are held in a window of WINDOW slots and released in order from
// the next expected number, up to 16 per arrival, the final result of each arrival
// marked by out_last. One transaction is handled at a time: a dropped arrival goes
// straight from evaluation to its result, a held one with nothing to release via
// a look-up, and each released operation through the controller sequence around
// the single-port slot memory (look up, registered read, present), each result
// held while the result side stalls. No clearing pass is needed after reset.
module sequence_reorder_release
  import srr_pkg::*;
#(
  parameter int WINDOW = 16
)(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SEQ_W-1:0]        in_seq,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic signed [POS_W-1:0] in_position,
  input  logic [TAG_W-1:0]        in_value_tag,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     out_status,
  output logic [SEQ_W-1:0]        out_seq,
  output logic [FUNC_W-1:0]       out_func,
  output logic signed [POS_W-1:0] out_position,
  output logic [TAG_W-1:0]        out_value_tag,
  output logic                    out_last
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  srr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // window, slot memory and result register
  srr_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_seq        (in_seq),
    .in_func       (in_func),
    .in_position   (in_position),
    .in_value_tag  (in_value_tag),
    .cmd           (cmd),
    .sts           (sts),
    .out_status    (out_status),
    .out_seq       (out_seq),
    .out_func      (out_func),
    .out_position  (out_position),
    .out_value_tag (out_value_tag),
    .out_last      (out_last)
  );

endmodule
